// ===== sv/expiring_alias_probe_table_top_assert.svh =====
// Assertion macros for the expiring alias probe table.
// No dependencies; included by expiring_alias_probe_table_top.sv.
`ifndef EXPIRING_ALIAS_PROBE_TABLE_TOP_ASSERT_SVH
`define EXPIRING_ALIAS_PROBE_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH

// Clocked assertion, disabled while reset is applied.
`define EAPT_ASSERT(lbl, clk_i, rst_n_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) \
		else $error("eapt assertion failed");

// Condition this cycle implies consequence in the next cycle.
`define EAPT_ASSERT_NEXT(lbl, clk_i, rst_n_i, cond, cons) \
	`EAPT_ASSERT(lbl, clk_i, rst_n_i, (cond) |=> (cons))

`else

`define EAPT_ASSERT(lbl, clk_i, rst_n_i, prop)
`define EAPT_ASSERT_NEXT(lbl, clk_i, rst_n_i, cond, cons)

`endif

`endif

// ===== sv/eapt_pkg.sv =====
// Package for the expiring alias probe table: sizes, slot and row types, opcodes.
// No dependencies.
`timescale 1ns / 1ps

package eapt_pkg;

	localparam int NUM_ALIASES     = 16;
	localparam int MAX_CONNECTIONS = 16;

	localparam int SLOT_W  = $clog2(NUM_ALIASES);
	localparam int ROW_AW  = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
	localparam int ID_W    = 32;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 5;
	localparam int EXT_W   = 9;  // holds any row or slot count up to 256

	localparam logic [CFG_W-1:0] CONN_IN_USE_RESET = 5'd16;
	localparam logic             REG_CONN_IN_USE   = 1'b0;

	typedef enum logic [1:0] {
		OP_LOOKUP  = 2'd0,
		OP_SET     = 2'd1,
		OP_CLR_ROW = 2'd2,
		OP_CLR_ALL = 2'd3
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] expiry;
	} slot_t;

	typedef slot_t [NUM_ALIASES-1:0] row_t;

endpackage

// ===== sv/expiring_alias_probe_table_top.sv =====
// Expiring alias probe table, top level: row memory, lookup pick, config register.
// Depends on eapt_pkg and expiring_alias_probe_table_top_assert.svh.
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-------------------------------------------------
// in      | in  | in_valid/in_ready  | opcode conn_handle object_id slot_index
//         |     |                    | expiry_time now_time
// out     | out | out_valid/out_ready| alias_found alias_slot
// cfg     | in  | APB psel/penable   | paddr pwdata -> connections_in_use, prdata
//
// Each transaction: the accept edge reads the whole connection row from the row
// memory, the done edge compares all slots, writes the row back and loads the
// result register; read and write-back share the one memory port. Reset needs no
// clearing pass: a valid flop per row marks rows in the reset state, and clear-all
// drops the flops of the first connections_in_use rows. A waiting result does not
// block the next transaction; only a second finished result with the register full stalls.
`timescale 1ns / 1ps

`include "expiring_alias_probe_table_top_assert.svh"

module expiring_alias_probe_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic [3:0]                      conn_handle,
	input  logic signed [eapt_pkg::ID_W-1:0]   object_id,
	input  logic [3:0]                      slot_index,
	input  logic signed [eapt_pkg::TIME_W-1:0] expiry_time,
	input  logic signed [eapt_pkg::TIME_W-1:0] now_time,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            alias_found,
	output logic [3:0]                      alias_slot,
	// config port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	import eapt_pkg::*;

	// ------------------------------------------------------------------
	// Config register
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] conn_in_use_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CONN_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_in_use_q <= CONN_IN_USE_RESET;
		end else if (cfg_wr) begin
			conn_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CONN_IN_USE) ? {{(32-CFG_W){1'b0}}, conn_in_use_q}
	                                              : 32'd0;

	// ------------------------------------------------------------------
	// Request decode at accept
	// ------------------------------------------------------------------
	logic              in_accept;
	logic              done;
	logic [EXT_W-1:0]  row_ext;
	logic [EXT_W-1:0]  slot_ext;
	logic [ROW_AW-1:0] row_idx;
	logic [SLOT_W-1:0] start_idx;

	assign in_accept = in_valid && in_ready;
	assign row_ext   = EXT_W'(conn_handle);
	assign slot_ext  = EXT_W'(slot_index);
	assign row_idx   = row_ext[ROW_AW-1:0];
	// probe start: low id byte folded into the row
	assign start_idx = SLOT_W'(EXT_W'(object_id[7:0]) % EXT_W'(NUM_ALIASES));

	// ------------------------------------------------------------------
	// Stage 1 registers (one transaction in flight)
	// ------------------------------------------------------------------
	logic              busy_s1;
	op_t               op_s1;
	logic              row_ok_s1;
	logic              slot_ok_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [SLOT_W-1:0] start_s1;
	logic [ID_W-1:0]   obj_s1;
	logic [TIME_W-1:0] exp_s1;
	logic [TIME_W-1:0] now_s1;
	logic              rowv_s1;
	row_t              rd_s1;

	assign in_ready = !busy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_accept) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1      <= op_t'(opcode);
			row_ok_s1  <= row_ext < EXT_W'(MAX_CONNECTIONS);
			slot_ok_s1 <= slot_ext < EXT_W'(NUM_ALIASES);
			row_s1     <= row_idx;
			slot_s1    <= slot_ext[SLOT_W-1:0];
			start_s1   <= start_idx;
			obj_s1     <= object_id;
			exp_s1     <= expiry_time;
			now_s1     <= now_time;
		end
	end

	// ------------------------------------------------------------------
	// Row memory plus per-row valid flops (invalid row = reset contents)
	// ------------------------------------------------------------------
	row_t                       row_mem [MAX_CONNECTIONS];
	logic [MAX_CONNECTIONS-1:0] row_valid_q;
	logic                       wr_en;
	logic                       clr_all;
	row_t                       wr_row;
	row_t                       base_row;
	logic [EXT_W-1:0]           clr_count;

	always_ff @(posedge clk) begin
		if (done && wr_en) begin
			row_mem[row_s1] <= wr_row;
		end
		if (in_accept) begin
			rd_s1 <= row_mem[row_idx];
		end
	end

	// write-back lands at the done edge; the next read comes at a later accept edge, once busy clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_s1 <= 1'b0;
		end else if (in_accept) begin
			rowv_s1 <= row_valid_q[row_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (done) begin
			if (wr_en) begin
				row_valid_q[row_s1] <= 1'b1;
			end
			if (clr_all) begin
				for (int r = 0; r < MAX_CONNECTIONS; r++) begin
					if (EXT_W'(r) < clr_count) begin
						row_valid_q[r] <= 1'b0;
					end
				end
			end
		end
	end

	// clear-all count saturates at the row count
	assign clr_count = (EXT_W'(conn_in_use_q) > EXT_W'(MAX_CONNECTIONS))
	                   ? EXT_W'(MAX_CONNECTIONS) : EXT_W'(conn_in_use_q);

	assign base_row = rowv_s1 ? rd_s1 : '1;

	// ------------------------------------------------------------------
	// Modify: set, clear-row, clear-all
	// ------------------------------------------------------------------
	always_comb begin
		wr_en   = 1'b0;
		clr_all = 1'b0;
		wr_row  = base_row;
		unique case (op_s1)
			OP_LOOKUP: begin
			end
			OP_SET: begin
				if (row_ok_s1 && slot_ok_s1) begin
					wr_en           = 1'b1;
					wr_row[slot_s1] = '{id: obj_s1, expiry: exp_s1};
				end
			end
			OP_CLR_ROW: begin
				if (row_ok_s1) begin
					wr_en = 1'b1;
					for (int s = 0; s < NUM_ALIASES; s++) begin
						wr_row[s] = '{id: '0, expiry: '1};
					end
				end
			end
			OP_CLR_ALL: begin
				clr_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Lookup: compare every slot, then first match from the start slot on,
	// wrapping to the bottom of the row.
	// ------------------------------------------------------------------
	logic [NUM_ALIASES-1:0] match;
	logic [NUM_ALIASES-1:0] live;
	logic [NUM_ALIASES-1:0] upper;
	logic [SLOT_W-1:0]      pick;
	logic                   hit;

	function automatic logic [SLOT_W-1:0] lowest_set(input logic [NUM_ALIASES-1:0] v);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = NUM_ALIASES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

	always_comb begin
		for (int s = 0; s < NUM_ALIASES; s++) begin
			match[s] = base_row[s].id == obj_s1;
			live[s]  = (base_row[s].expiry != '1) &&
			           !($signed(now_s1) > $signed(base_row[s].expiry));
			upper[s] = match[s] && (SLOT_W'(s) >= start_s1);
		end
		pick = (|upper) ? lowest_set(upper) : lowest_set(match);
		hit  = (op_s1 == OP_LOOKUP) && row_ok_s1 && (|match) && live[pick];
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic             out_valid_q;
	logic             alias_found_q;
	logic [3:0]       alias_slot_q;

	assign done = busy_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			alias_found_q <= hit;
			alias_slot_q  <= hit ? 4'(pick) : 4'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign alias_found = alias_found_q;
	assign alias_slot  = alias_slot_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`EAPT_ASSERT(a_no_accept_busy, clk, arst_n, busy_s1 |-> !in_ready)
	`EAPT_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_accept, busy_s1)
	`EAPT_ASSERT_NEXT(a_done_result, clk, arst_n, done, out_valid && !busy_s1)
	`EAPT_ASSERT(a_miss_slot_zero, clk, arst_n, (out_valid && !alias_found) |-> alias_slot == 4'd0)

endmodule
